// ===== rtl/fss_pkg.sv =====
// Shared types, constants and helpers of the fuzzy subsequence scorer.
`default_nettype none
package fss_pkg;

    localparam int MAX_QUERY_BYTES = 32;
    localparam int POS_W           = 6;   // holds 0 .. MAX_QUERY_BYTES
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int SCORE_W         = 7;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_BYTES_A = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_BYTES_B = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_BYTES_C = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_BYTES_D = 3'd4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [SCORE_W-1:0] ADD_RUN   = 7'd3;
    localparam logic [SCORE_W-1:0] ADD_WORD  = 7'd2;
    localparam logic [SCORE_W-1:0] ADD_PLAIN = 7'd1;
    localparam logic [SCORE_W-1:0] ADD_HEAD  = 7'd2;

    localparam logic [7:0] SCORE_NO_MATCH = 8'hFF;

    // Query view handed from the register file to the match stage
    typedef struct packed {
        logic [POS_W-1:0]                  len;         // clamped length
        logic [MAX_QUERY_BYTES-1:0]        in_use;      // index below length
        logic [MAX_QUERY_BYTES-1:0]        is_space;    // lowered byte is a space
        logic [MAX_QUERY_BYTES-1:0][7:0]   bytes;       // lowered query bytes
    } query_info_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fss_query_regs.sv =====
// Configuration registers holding the query, with lowered bytes and masks.
`default_nettype none
module fss_query_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fss_pkg::query_info_t                   query
);

    logic [fss_pkg::POS_W-1:0]      length_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] word_a_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] word_b_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] word_c_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] word_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            word_a_reg <= '0;
            word_b_reg <= '0;
            word_c_reg <= '0;
            word_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fss_pkg::CFG_NEEDLE_LENGTH:  length_reg <= cfg_data[fss_pkg::POS_W-1:0];
                fss_pkg::CFG_NEEDLE_BYTES_A: word_a_reg <= cfg_data;
                fss_pkg::CFG_NEEDLE_BYTES_B: word_b_reg <= cfg_data;
                fss_pkg::CFG_NEEDLE_BYTES_C: word_c_reg <= cfg_data;
                fss_pkg::CFG_NEEDLE_BYTES_D: word_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [fss_pkg::MAX_QUERY_BYTES-1:0][7:0] raw_bytes;
    logic [fss_pkg::POS_W-1:0]                len_clamped;

    assign raw_bytes   = {word_d_reg, word_c_reg, word_b_reg, word_a_reg};
    assign len_clamped = (length_reg > fss_pkg::POS_W'(fss_pkg::MAX_QUERY_BYTES))
                       ? fss_pkg::POS_W'(fss_pkg::MAX_QUERY_BYTES) : length_reg;

    always_comb
    begin
        query.len = len_clamped;
        for (int i = 0; i < fss_pkg::MAX_QUERY_BYTES; i++)
        begin
            query.bytes[i]    = fss_pkg::lower_byte(raw_bytes[i]);
            query.is_space[i] = (query.bytes[i] == fss_pkg::CHAR_SPACE);
            query.in_use[i]   = (fss_pkg::POS_W'(i) < len_clamped);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fss_match_stage.sv =====
// Per-byte match logic, label state registers and the result register.
`default_nettype none
module fss_match_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fss_pkg::query_info_t  query,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            label_byte,
    input  wire logic                  byte_present,
    input  wire logic                  end_of_label,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [7:0]          match_score,
    output logic                       is_match
);

    localparam int N = fss_pkg::MAX_QUERY_BYTES;

    logic [fss_pkg::POS_W-1:0]   pos_reg,   pos_next;
    logic                        run_reg,   run_next;
    logic [7:0]                  prev_reg,  prev_next;
    logic                        head_reg,  head_next;
    logic [fss_pkg::SCORE_W-1:0] score_reg, score_next;

    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_score_reg, out_score_next;
    logic                        out_match_reg, out_match_next;

    logic accept;

    // Lowest set bit of the vector, or N when none is set; the caller masks it to the current position and up
    function automatic logic [fss_pkg::POS_W-1:0] first_set(input logic [N:0] v);
        logic [fss_pkg::POS_W-1:0] idx;
        idx = fss_pkg::POS_W'(N);
        for (int i = N; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = fss_pkg::POS_W'(i);
            end
        end
        return idx;
    endfunction

    logic [N-1:0]                stop_mask;
    logic [N-1:0]                nonspace;
    logic [fss_pkg::POS_W-1:0]   q;
    logic [fss_pkg::POS_W-1:0]   q_plus;
    logic                        skipped;
    logic                        q_live;
    logic                        matched;
    logic                        word_start;
    logic                        ns_above;
    logic                        done;
    logic [fss_pkg::SCORE_W-1:0] add;
    logic [fss_pkg::SCORE_W-1:0] score_step;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;

    always_comb
    begin
        stop_mask = ~query.in_use | ~query.is_space;
        nonspace  = query.in_use & ~query.is_space;

        // Skip query spaces from the current position
        q       = first_set({1'b1, stop_mask} & ({(N+1){1'b1}} << pos_reg));
        skipped = (q != pos_reg);
        q_live  = (q < query.len);
        q_plus  = q + fss_pkg::POS_W'(1);

        matched = byte_present && q_live
               && (fss_pkg::lower_byte(label_byte) == query.bytes[q[fss_pkg::POS_W-2:0]]);

        word_start = head_reg
                  || prev_reg == fss_pkg::CHAR_SPACE || prev_reg == fss_pkg::CHAR_COLON
                  || prev_reg == fss_pkg::CHAR_SLASH || prev_reg == fss_pkg::CHAR_DOT;

        if (run_reg && !skipped)
        begin
            add = fss_pkg::ADD_RUN;
        end
        else if (word_start)
        begin
            add = fss_pkg::ADD_WORD;
        end
        else
        begin
            add = fss_pkg::ADD_PLAIN;
        end
        if (head_reg)
        begin
            add = add + fss_pkg::ADD_HEAD;
        end
        score_step = matched ? score_reg + add : score_reg;

        ns_above = |(nonspace & ({N{1'b1}} << q_plus));
        done     = matched ? !ns_above : !q_live;

        // Hold state on idle cycles and absent bytes
        pos_next   = pos_reg;
        run_next   = run_reg;
        prev_next  = prev_reg;
        head_next  = head_reg;
        score_next = score_reg;
        if (accept && byte_present)
        begin
            pos_next   = matched ? q_plus : q;
            run_next   = matched ? 1'b1 : ((q_live || skipped) ? 1'b0 : run_reg);
            prev_next  = label_byte;
            head_next  = 1'b0;
            score_next = score_step;
        end
        if (accept && end_of_label)
        begin
            pos_next   = '0;
            run_next   = 1'b0;
            prev_next  = '0;
            head_next  = 1'b1;
            score_next = '0;
        end

        out_valid_next = out_valid_reg && out_stall;
        out_score_next = out_score_reg;
        out_match_next = out_match_reg;
        if (accept && end_of_label)
        begin
            out_valid_next = 1'b1;
            out_score_next = done ? {1'b0, score_step} : fss_pkg::SCORE_NO_MATCH;
            out_match_next = done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            run_reg       <= 1'b0;
            prev_reg      <= '0;
            head_reg      <= 1'b1;
            score_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            run_reg       <= run_next;
            prev_reg      <= prev_next;
            head_reg      <= head_next;
            score_reg     <= score_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_score_reg <= out_score_next;
        out_match_reg <= out_match_next;
    end

    assign out_valid   = out_valid_reg;
    assign match_score = out_score_reg;
    assign is_match    = out_match_reg;

endmodule
`default_nettype wire

// ===== rtl/fuzzy_subsequence_scorer_core.sv =====
// Top level of the fuzzy subsequence scorer: query registers and match stage.
//
// Scores a label, streamed one byte per request, against a query of up to
// 32 bytes held in the configuration registers. Matching ignores case for
// A-Z; query spaces are skipped and break a run. The block takes one
// request per clock while in_stall is low; the single result of a label
// appears in the result register in the cycle after its end_of_label
// request and holds while out_stall is high.
// A new byte request is taken even while a result waits; only while the
// waiting result is held by out_stall does in_stall rise, for any request.
// The result is the score (0..127) with is_match high, or -1 with is_match
// low when the query is not a subsequence of the label.
// An empty query (length zero or spaces only) scores 0 for every label.
// Write the configuration port only while no label is in flight; a length
// above 32 is taken as 32.
`default_nettype none
module fuzzy_subsequence_scorer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [fss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]    cfg_data,
    // label byte requests
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        label_byte,
    input  wire logic                              byte_present,
    input  wire logic                              end_of_label,
    // result requests
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [7:0]                      match_score,
    output logic                                   is_match
);

    fss_pkg::query_info_t query;

    // Hold the query and present it lowered, with in-use and space masks
    fss_query_regs u_query_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .query     (query)
    );

    // Advance the label state one byte per request and register the result
    fss_match_stage u_match_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .query        (query),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .label_byte   (label_byte),
        .byte_present (byte_present),
        .end_of_label (end_of_label),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_score  (match_score),
        .is_match     (is_match)
    );

endmodule
`default_nettype wire

// ===== sim/tb_fuzzy_subsequence_scorer_core.sv =====
// Testbench for fuzzy_subsequence_scorer_core: directed and random queries and labels, every score checked.
module tb_fuzzy_subsequence_scorer_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted request before the run is declared hung.
    // The worst honest gap is a sender idle burst behind a result stall
    // plus a short drain, so this is many times over.
    localparam int QUIET_LIMIT  = 2000;
    // The result register sits behind the label state; give it slack.
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int ITEM_TARGET  = 1200;
    // Past this many items both sides stop idling.
    localparam int CALM_AFTER   = 1050;

    // Register write order of the configuration port
    localparam logic [fss_pkg::CFG_INDEX_W-1:0] REG_ORDER [5] = '{
        fss_pkg::CFG_NEEDLE_LENGTH, fss_pkg::CFG_NEEDLE_BYTES_A,
        fss_pkg::CFG_NEEDLE_BYTES_B, fss_pkg::CFG_NEEDLE_BYTES_C,
        fss_pkg::CFG_NEEDLE_BYTES_D
    };

    typedef struct packed {
        logic signed [7:0] score;
        logic              matched;
    } label_score_t;

    // Mirrors the query registers and the per-label match state, and keeps
    // the scores still owed by the block in request order.
    class score_predictor;
        bit [5:0]     needle_len;
        bit [63:0]    needle_word [4];
        bit [5:0]     query_pos;
        bit           in_run;
        bit [7:0]     last_byte;
        bit           at_head;
        bit [6:0]     score_sum;
        label_score_t owed_scores [$];
        int           errors;

        function new();
            needle_len = '0;
            foreach (needle_word[i])
            begin
                needle_word[i] = '0;
            end
            errors = 0;
            clear_label();
        endfunction

        function void clear_label();
            query_pos = '0;
            in_run    = 1'b0;
            last_byte = '0;
            at_head   = 1'b1;
            score_sum = '0;
        endfunction

        function bit [7:0] fold_case(bit [7:0] c);
            if (c >= fss_pkg::CHAR_UPPER_A && c <= fss_pkg::CHAR_UPPER_Z)
            begin
                return c + fss_pkg::CASE_OFFSET;
            end
            return c;
        endfunction

        function int query_length();
            int n;
            n = needle_len;
            return (n > fss_pkg::MAX_QUERY_BYTES) ? fss_pkg::MAX_QUERY_BYTES : n;
        endfunction

        function bit [7:0] query_char(int i);
            bit [63:0] w;
            w = needle_word[i >> 3];
            return fold_case(w[(i & 7) * 8 +: 8]);
        endfunction

        // Step over query spaces; each one breaks the run.
        function void skip_spaces();
            while (query_pos < query_length()
                   && query_char(query_pos) == fss_pkg::CHAR_SPACE)
            begin
                in_run = 1'b0;
                query_pos++;
            end
        endfunction

        function void write_register(bit [fss_pkg::CFG_INDEX_W-1:0] idx, bit [63:0] data);
            case (idx)
                fss_pkg::CFG_NEEDLE_LENGTH:  needle_len     = data[5:0];
                fss_pkg::CFG_NEEDLE_BYTES_A: needle_word[0] = data;
                fss_pkg::CFG_NEEDLE_BYTES_B: needle_word[1] = data;
                fss_pkg::CFG_NEEDLE_BYTES_C: needle_word[2] = data;
                fss_pkg::CFG_NEEDLE_BYTES_D: needle_word[3] = data;
                default: ;
            endcase
        endfunction

        function void take_request(bit [7:0] b, bit present, bit last);
            bit           word_start;
            bit [6:0]     add;
            label_score_t r;
            if (present)
            begin
                skip_spaces();
                if (query_pos < query_length())
                begin
                    if (fold_case(b) == query_char(query_pos))
                    begin
                        word_start = at_head || last_byte == fss_pkg::CHAR_SPACE ||
                                     last_byte == fss_pkg::CHAR_COLON ||
                                     last_byte == fss_pkg::CHAR_SLASH ||
                                     last_byte == fss_pkg::CHAR_DOT;
                        add = in_run ? fss_pkg::ADD_RUN
                                     : (word_start ? fss_pkg::ADD_WORD : fss_pkg::ADD_PLAIN);
                        if (at_head)
                        begin
                            add += fss_pkg::ADD_HEAD;
                        end
                        score_sum += add;
                        in_run = 1'b1;
                        query_pos++;
                    end
                    else
                    begin
                        in_run = 1'b0;
                    end
                end
                last_byte = b;
                at_head   = 1'b0;
            end
            if (last)
            begin
                skip_spaces();
                if (query_pos >= query_length())
                begin
                    r.score   = {1'b0, score_sum};
                    r.matched = 1'b1;
                end
                else
                begin
                    r.score   = fss_pkg::SCORE_NO_MATCH;
                    r.matched = 1'b0;
                end
                owed_scores.insert(owed_scores.size(), r);
                clear_label();
            end
        endfunction

        function void check_result(logic signed [7:0] score, logic matched);
            label_score_t want;
            if (owed_scores.size() == 0)
            begin
                $error("unexpected result: match_score %0d is_match %0b", score, matched);
                errors++;
                return;
            end
            want = owed_scores.pop_front();
            if (score !== want.score)
            begin
                $error("match_score: expected %0d, actual %0d", want.score, score);
                errors++;
            end
            if (matched !== want.matched)
            begin
                $error("is_match: expected %0b, actual %0b", want.matched, matched);
                errors++;
            end
        endfunction

        function int pending();
            return owed_scores.size();
        endfunction
    endclass

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_we       = 1'b0;
    logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_stall;
    logic [7:0]                      label_byte   = '0;
    logic                            byte_present = 1'b0;
    logic                            end_of_label = 1'b0;
    logic                            out_valid;
    logic                            out_stall    = 1'b0;
    logic signed [7:0]               match_score;
    logic                            is_match;

    score_predictor tracker = new();
    bit [63:0]      reg_image [5];
    bit             idle_on = 1'b1;
    int             items_sent = 0;
    int             stall_left = 0;
    int             quiet_cycles = 0;

    fuzzy_subsequence_scorer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .label_byte   (label_byte),
        .byte_present (byte_present),
        .end_of_label (end_of_label),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_score  (match_score),
        .is_match     (is_match)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Present one label request and hold it until the block takes it.
    // An optional idle burst goes first; valid is only lowered for a burst,
    // so back-to-back requests keep it high across the edge.
    task automatic send_request(input bit [7:0] b, input bit present, input bit last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        label_byte   <= b;
        byte_present <= present;
        end_of_label <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tracker.take_request(b, present, last);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_request(s[i], 1'b1, i == s.len() - 1);
        end
    endtask

    // Write all five query registers back to back, then drop the enable.
    task automatic program_needle();
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= reg_image[i];
            @(posedge clk);
            tracker.write_register(REG_ORDER[i], reg_image[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Stop sending, wait out every owed score, then let the match stage empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Small alphabet so that random queries and labels collide often.
    function automatic bit [7:0] pick_char();
        case ($urandom_range(0, 15))
            0:       return fss_pkg::CHAR_SPACE;
            1:       return fss_pkg::CHAR_COLON;
            2:       return fss_pkg::CHAR_SLASH;
            3:       return fss_pkg::CHAR_DOT;
            4:       return 8'h00;
            5:       return 8'($urandom_range(0, 255));
            6, 7, 8, 9, 10: return 8'h61 + 8'($urandom_range(0, 5));
            default: return fss_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 5));
        endcase
    endfunction

    task automatic roll_needle();
        bit [5:0] len;
        int       mode;
        case ($urandom_range(0, 9))
            0:       len = 6'd0;
            1:       len = 6'(fss_pkg::MAX_QUERY_BYTES);
            2:       len = 6'($urandom_range(fss_pkg::MAX_QUERY_BYTES + 1, 63));
            3, 4:    len = 6'($urandom_range(1, fss_pkg::MAX_QUERY_BYTES));
            default: len = 6'($urandom_range(1, 6));
        endcase
        // Upper bits of the length word may be junk that the register must ignore.
        reg_image[0] = ($urandom_range(0, 1) == 0) ? 64'd0 : {$urandom(), $urandom()};
        reg_image[0][5:0] = len;
        mode = $urandom_range(0, 7);
        for (int w = 1; w < 5; w++)
        begin
            case (mode)
                0:       reg_image[w] = '0;
                1:       reg_image[w] = '1;
                2:       reg_image[w] = {$urandom(), $urandom()};
                default:
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        reg_image[w][k * 8 +: 8] = pick_char();
                    end
                end
            endcase
        end
    endtask

    // Build one label: mostly the query woven into filler with random case,
    // sometimes with a query byte dropped, plus pure noise and empty labels.
    task automatic send_random_label();
        bit [7:0] seq_byte [$];
        bit       seq_here [$];
        bit [7:0] c;
        int       kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(0, 12))
            begin
                seq_byte.insert(seq_byte.size(), 8'($urandom_range(0, 255)));
                seq_here.insert(seq_here.size(), $urandom_range(0, 7) != 0);
            end
        end
        else if (kind != 1)
        begin
            for (int i = 0; i < tracker.query_length(); i++)
            begin
                c = tracker.query_char(i);
                if ($urandom_range(0, 11) == 0)
                begin
                    seq_byte.insert(seq_byte.size(), 8'($urandom_range(0, 255)));
                    seq_here.insert(seq_here.size(), 1'b0);
                end
                while ($urandom_range(0, 3) == 0)
                begin
                    seq_byte.insert(seq_byte.size(), pick_char());
                    seq_here.insert(seq_here.size(), 1'b1);
                end
                if (c == fss_pkg::CHAR_SPACE || $urandom_range(0, 11) == 0)
                begin
                    continue;
                end
                if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
                begin
                    c -= fss_pkg::CASE_OFFSET;
                end
                seq_byte.insert(seq_byte.size(), c);
                seq_here.insert(seq_here.size(), 1'b1);
            end
            repeat ($urandom_range(0, 2))
            begin
                seq_byte.insert(seq_byte.size(), pick_char());
                seq_here.insert(seq_here.size(), 1'b1);
            end
        end
        // Close either on the last real byte or on an absent marker.
        if (seq_byte.size() == 0 || $urandom_range(0, 4) == 0)
        begin
            foreach (seq_byte[i])
            begin
                send_request(seq_byte[i], seq_here[i], 1'b0);
            end
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        else
        begin
            foreach (seq_byte[i])
            begin
                send_request(seq_byte[i], seq_here[i], i == seq_byte.size() - 1);
            end
        end
    endtask

    // Result side: check each accepted result, then stall in random bursts.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.check_result(match_score, is_match);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a request.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset query is empty: an empty label and a plain one both score 0.
        send_request(8'h00, 1'b0, 1'b1);
        send_text("Ab");
        drain();

        // Query "aB c": head bonus, run, space break, word start after colon.
        reg_image = '{64'd4, 64'h0000_0000_6320_4261, 64'd0, 64'd0, 64'd0};
        program_needle();
        send_text("AB:c");
        send_request(8'h00, 1'b0, 1'b1);
        // Extreme bytes and absent markers, query left uncovered.
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1);
        drain();

        // A zero query byte is an ordinary byte.
        reg_image = '{64'd2, 64'h0000_0000_0000_4100, 64'd0, 64'd0, 64'd0};
        program_needle();
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'h61, 1'b1, 1'b1);
        drain();

        // Query of spaces only behaves as empty.
        reg_image = '{64'd3, 64'h0000_0000_0020_2020, 64'd0, 64'd0, 64'd0};
        program_needle();
        send_text("q");
        drain();

        // Once the query is covered, later bytes add nothing.
        reg_image = '{64'd1, 64'h0000_0000_0000_0041, 64'd0, 64'd0, 64'd0};
        program_needle();
        send_text("aaZ");
        drain();

        // Random phases: new query, a handful of labels, drain before rewrite.
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            roll_needle();
            program_needle();
            repeat ($urandom_range(3, 8)) send_random_label();
            drain();
        end
        idle_on = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
